// File: hdl/cna_pkg.sv
package cna_pkg;

    localparam int RES_W = 48;
    localparam int MAG_W = 64;

    localparam logic [2:0] ACT_ADD  = 3'd0;
    localparam logic [2:0] ACT_SUB  = 3'd1;
    localparam logic [2:0] ACT_MUL  = 3'd2;
    localparam logic [2:0] ACT_DIV  = 3'd3;
    localparam logic [2:0] ACT_MAG  = 3'd4;
    localparam logic [2:0] ACT_CONJ = 3'd5;

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (RES_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (RES_W - 1));

    typedef struct packed {
        logic       valid;
        logic [2:0] act;
        logic       neg_re;
        logic       neg_im;
        logic       div_zero;
    } ctl_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [RES_W-1:0] sim_re;
        logic [RES_W-1:0] sim_im;
    } side_t;

    // clamp a sign and magnitude pair to the signed result range
    function automatic logic [RES_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        begin
            if (neg)
            begin
                m = (mag > NEG_LIM) ? NEG_LIM : mag;
                m = ~m + MAG_W'(1);
            end
            else
            begin
                m = (mag > POS_LIM) ? POS_LIM : mag;
            end
            return m[RES_W-1:0];
        end
    endfunction

endpackage

// File: hdl/cna_front.sv
module cna_front
    import cna_pkg::*;
#(
    parameter int OW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2:0]           act,
    input  logic signed [OW-1:0] a1,
    input  logic signed [OW-1:0] b1,
    input  logic signed [OW-1:0] a2,
    input  logic signed [OW-1:0] b2,
    output ctl_t                 ctl,
    output logic signed [2*OW:0] int_re,
    output logic signed [2*OW:0] int_im,
    output logic [2*OW-1:0]      num_re,
    output logic [2*OW-1:0]      num_im,
    output logic [2*OW-1:0]      den,
    output logic [2*OW-1:0]      sq
);
    localparam int PW = 2 * OW;

    logic                 v1_reg;
    logic [2:0]           act1_reg;
    logic signed [OW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [PW-1:0] p_a1a2_reg, p_b1b2_reg, p_a1b2_reg, p_a2b1_reg;
    logic signed [PW-1:0] p_a2a2_reg, p_b2b2_reg, p_a1a1_reg, p_b1b1_reg;

    ctl_t                 ctl_reg, ctl_next;
    logic signed [PW:0]   int_re_reg, int_re_next, int_im_reg, int_im_next;
    logic [PW-1:0]        num_re_reg, num_re_next, num_im_reg, num_im_next;
    logic [PW-1:0]        den_reg, den_next, sq_reg, sq_next;

    logic signed [PW:0]   dr, di, mr, mi;
    logic [PW:0]          dr_abs, di_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg   <= act;
            a1_reg     <= a1;
            b1_reg     <= b1;
            a2_reg     <= a2;
            b2_reg     <= b2;
            p_a1a2_reg <= a1 * a2;
            p_b1b2_reg <= b1 * b2;
            p_a1b2_reg <= a1 * b2;
            p_a2b1_reg <= a2 * b1;
            p_a2a2_reg <= a2 * a2;
            p_b2b2_reg <= b2 * b2;
            p_a1a1_reg <= a1 * a1;
            p_b1b1_reg <= b1 * b1;
            int_re_reg <= int_re_next;
            int_im_reg <= int_im_next;
            num_re_reg <= num_re_next;
            num_im_reg <= num_im_next;
            den_reg    <= den_next;
            sq_reg     <= sq_next;
        end
    end

    always_comb
    begin
        mr = (PW+1)'(p_a1a2_reg) - (PW+1)'(p_b1b2_reg);
        mi = (PW+1)'(p_a1b2_reg) + (PW+1)'(p_a2b1_reg);
        dr = (PW+1)'(p_a1a2_reg) + (PW+1)'(p_b1b2_reg);
        di = (PW+1)'(p_a2b1_reg) - (PW+1)'(p_a1b2_reg);
        dr_abs = dr[PW] ? (PW+1)'(-dr) : (PW+1)'(dr);
        di_abs = di[PW] ? (PW+1)'(-di) : (PW+1)'(di);

        den_next    = PW'(p_a2a2_reg) + PW'(p_b2b2_reg);
        sq_next     = PW'(p_a1a1_reg) + PW'(p_b1b1_reg);
        num_re_next = dr_abs[PW-1:0];
        num_im_next = di_abs[PW-1:0];

        ctl_next.valid    = v1_reg;
        ctl_next.act      = act1_reg;
        ctl_next.neg_re   = dr[PW];
        ctl_next.neg_im   = di[PW];
        ctl_next.div_zero = (den_next == '0);

        case (act1_reg)
            ACT_ADD:
            begin
                int_re_next = (PW+1)'(a1_reg) + (PW+1)'(a2_reg);
                int_im_next = (PW+1)'(b1_reg) + (PW+1)'(b2_reg);
            end
            ACT_SUB:
            begin
                int_re_next = (PW+1)'(a1_reg) - (PW+1)'(a2_reg);
                int_im_next = (PW+1)'(b1_reg) - (PW+1)'(b2_reg);
            end
            ACT_MUL:
            begin
                int_re_next = mr;
                int_im_next = mi;
            end
            ACT_CONJ:
            begin
                int_re_next = (PW+1)'(a1_reg);
                int_im_next = -((PW+1)'(b1_reg));
            end
            default:
            begin
                int_re_next = '0;
                int_im_next = '0;
            end
        endcase
    end

    assign ctl    = ctl_reg;
    assign int_re = int_re_reg;
    assign int_im = int_im_reg;
    assign num_re = num_re_reg;
    assign num_im = num_im_reg;
    assign den    = den_reg;
    assign sq     = sq_reg;

endmodule

// File: hdl/cna_div.sv
module cna_div #(
    parameter int NUM_W = 32,
    parameter int FRAC  = 16
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [NUM_W-1:0]      num,
    input  logic [NUM_W-1:0]      den,
    output logic [NUM_W+FRAC-1:0] quo
);
    localparam int QW = NUM_W + FRAC;

    // each stage shifts one dividend bit out of the top and one quotient bit in
    logic [QW-1:0]    word_reg [QW];
    logic [NUM_W-1:0] rem_reg  [QW];
    logic [NUM_W-1:0] den_reg  [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [QW-1:0]    w_in;
            logic [NUM_W-1:0] r_in, d_in;
            logic [NUM_W:0]   t;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign w_in = {num, FRAC'(0)};
                assign r_in = '0;
                assign d_in = den;
            end
            else
            begin : g_next
                assign w_in = word_reg[k-1];
                assign r_in = rem_reg[k-1];
                assign d_in = den_reg[k-1];
            end

            assign t  = {r_in, w_in[QW-1]};
            assign ge = (t >= {1'b0, d_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    word_reg[k] <= {w_in[QW-2:0], ge};
                    rem_reg[k]  <= ge ? NUM_W'(t - {1'b0, d_in}) : NUM_W'(t);
                    den_reg[k]  <= d_in;
                end
            end
        end
    endgenerate

    assign quo = word_reg[QW-1];

endmodule

// File: hdl/cna_sqrt.sv
module cna_sqrt #(
    parameter int IN_W = 32,
    parameter int FRAC = 16
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [IN_W-1:0]            sq,
    output logic [IN_W/2+FRAC-1:0]     root
);
    localparam int RT_W = IN_W / 2 + FRAC;
    localparam int XW   = 2 * RT_W;

    // one root bit per stage, radicand bit pairs shift out of the top
    logic [XW-1:0]   x_reg    [RT_W];
    logic [RT_W+1:0] rem_reg  [RT_W];
    logic [RT_W-1:0] root_reg [RT_W];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++)
        begin : g_stage
            logic [XW-1:0]   x_in;
            logic [RT_W+1:0] r_in;
            logic [RT_W-1:0] q_in;
            logic [RT_W+3:0] t, trial;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign x_in = {sq, (2*FRAC)'(0)};
                assign r_in = '0;
                assign q_in = '0;
            end
            else
            begin : g_next
                assign x_in = x_reg[k-1];
                assign r_in = rem_reg[k-1];
                assign q_in = root_reg[k-1];
            end

            assign t     = {r_in, x_in[XW-1:XW-2]};
            assign trial = (RT_W+4)'({q_in, 2'b01});
            assign ge    = (t >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= {x_in[XW-3:0], 2'b00};
                    rem_reg[k]  <= ge ? (RT_W+2)'(t - trial) : (RT_W+2)'(t);
                    root_reg[k] <= {q_in[RT_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign root = root_reg[RT_W-1];

endmodule

// File: hdl/complex_number_alu.sv
// Fully pipelined complex ALU: one word accepted per clock, one result per word, in order.
// The pipeline has two stages of products and sums, then the restoring divider with one
// quotient bit per stage, whose depth sets the latency of every action, then the output
// register. The square root runs in parallel with one root bit per stage and is delayed
// to line up. A stalled output freezes the whole pipeline; s_axis_tready is low only
// while a result waits unaccepted.
module complex_number_alu
    import cna_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // first_real, first_imag, second_real, second_imag, zero fill
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    // action
    input  logic [2:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // result_real, result_imag
    output logic [2*RES_W-1:0]                    m_axis_tdata,
    // status
    output logic                                  m_axis_tuser
);
    localparam int OW   = OPERAND_WIDTH;
    localparam int PW   = 2 * OW;
    localparam int QW   = PW + FRACTION_BITS;
    localparam int RT_W = OW + FRACTION_BITS;
    localparam int XD   = QW - RT_W;

    logic en;

    ctl_t               f_ctl;
    logic signed [PW:0] f_int_re, f_int_im;
    logic [PW-1:0]      f_num_re, f_num_im, f_den, f_sq;
    logic [PW:0]        abs_re, abs_im;

    side_t              side_reg [QW];
    logic [QW-1:0]      q_re, q_im;
    logic [RT_W-1:0]    root;
    logic [RT_W-1:0]    rdly_reg [XD];

    side_t              last;
    logic               m_valid_reg;
    logic [RES_W-1:0]   re_reg, re_next, im_reg, im_next;
    logic               st_reg, st_next;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    cna_front #(.OW(OW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .act      (s_axis_tuser),
        .a1       (s_axis_tdata[OW-1:0]),
        .b1       (s_axis_tdata[2*OW-1:OW]),
        .a2       (s_axis_tdata[3*OW-1:2*OW]),
        .b2       (s_axis_tdata[4*OW-1:3*OW]),
        .ctl      (f_ctl),
        .int_re   (f_int_re),
        .int_im   (f_int_im),
        .num_re   (f_num_re),
        .num_im   (f_num_im),
        .den      (f_den),
        .sq       (f_sq)
    );

    cna_div #(.NUM_W(PW), .FRAC(FRACTION_BITS)) u_div_re (
        .clk (clk), .en (en), .num (f_num_re), .den (f_den), .quo (q_re)
    );

    cna_div #(.NUM_W(PW), .FRAC(FRACTION_BITS)) u_div_im (
        .clk (clk), .en (en), .num (f_num_im), .den (f_den), .quo (q_im)
    );

    cna_sqrt #(.IN_W(PW), .FRAC(FRACTION_BITS)) u_sqrt (
        .clk (clk), .en (en), .sq (f_sq), .root (root)
    );

    assign abs_re = f_int_re[PW] ? (PW+1)'(-f_int_re) : (PW+1)'(f_int_re);
    assign abs_im = f_int_im[PW] ? (PW+1)'(-f_int_im) : (PW+1)'(f_int_im);

    // side band travels alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0].ctl    <= f_ctl;
            side_reg[0].sim_re <= sat_mag(f_int_re[PW], MAG_W'(abs_re) << FRACTION_BITS);
            side_reg[0].sim_im <= sat_mag(f_int_im[PW], MAG_W'(abs_im) << FRACTION_BITS);
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // align the shorter root pipeline with the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdly_reg[0] <= root;
            for (int i = 1; i < XD; i++)
            begin
                rdly_reg[i] <= rdly_reg[i-1];
            end
        end
    end

    assign last = side_reg[QW-1];

    always_comb
    begin
        re_next = last.sim_re;
        im_next = last.sim_im;
        st_next = 1'b0;
        case (last.ctl.act)
            ACT_DIV:
            begin
                if (last.ctl.div_zero)
                begin
                    re_next = '0;
                    im_next = '0;
                    st_next = 1'b1;
                end
                else
                begin
                    re_next = sat_mag(last.ctl.neg_re, MAG_W'(q_re));
                    im_next = sat_mag(last.ctl.neg_im, MAG_W'(q_im));
                end
            end
            ACT_MAG:
            begin
                re_next = sat_mag(1'b0, MAG_W'(rdly_reg[XD-1]));
                im_next = '0;
            end
            default:
            begin
                re_next = last.sim_re;
                im_next = last.sim_im;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= last.ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {im_reg, re_reg};
    assign m_axis_tuser  = st_reg;

    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("division by zero result not cleared");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a waiting result");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(last.ctl.valid))
        else $error("pipeline advanced during stall");

endmodule
